@@ hdl/deq_pkg.sv @@
package deq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_WAIT,
    S_SCAN,
    S_RESP
  } state_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] popped_value;
    logic        [4:0]  found_position;
  } res_t;

endpackage

@@ hdl/deq_mem.sv @@
module deq_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/deq_seq.sv @@
module deq_seq
  import deq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_op,
  input  logic signed [31:0] in_value,
  output logic               res_valid,
  input  logic               res_ready,
  output res_t               res,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [31:0]        wr_data,
  output logic [AW-1:0]      rd_addr,
  input  logic [31:0]        rd_data
);

  state_t        state_r, state_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [31:0]   val_r, val_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] scan_slot_r, scan_slot_nxt;
  res_t          res_r, res_nxt;

  logic          full, empty;
  logic [CW-1:0] offset;
  logic [AW:0]   ring_sum;
  logic [AW-1:0] ring_slot;
  logic [AW-1:0] head_dec, head_inc, slot_inc;
  logic [CW-1:0] idx_inc;
  logic [31:0]   pos_wide;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  // One shared ring adder locates the back entry for both push back and pop back.
  assign offset    = (op_r == OP_PUSH_BACK) ? count_r : count_r - 1'b1;
  assign ring_sum  = (AW+1)'(head_r) + (AW+1)'(offset);
  assign ring_slot = (ring_sum >= (AW+1)'(DEPTH)) ? AW'(ring_sum - (AW+1)'(DEPTH))
                                                  : ring_sum[AW-1:0];

  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign slot_inc = (scan_slot_r == AW'(DEPTH - 1)) ? '0 : scan_slot_r + 1'b1;
  assign idx_inc  = idx_r + 1'b1;
  assign pos_wide = 32'(idx_r) + 32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    val_r       <= val_nxt;
    idx_r       <= idx_nxt;
    scan_slot_r <= scan_slot_nxt;
    res_r       <= res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    scan_slot_nxt = scan_slot_r;
    res_nxt       = res_r;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = head_r;
    wr_data       = val_r;
    rd_addr       = head_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt    = in_op;
          val_nxt   = in_value;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt   = '0;
        state_nxt = S_RESP;
        unique case (op_r)
          OP_PUSH_FRONT: begin
            if (full) begin
              res_nxt.status = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = head_dec;
              head_nxt  = head_dec;
              count_nxt = count_r + 1'b1;
            end
          end
          OP_PUSH_BACK: begin
            if (full) begin
              res_nxt.status = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = ring_slot;
              count_nxt = count_r + 1'b1;
            end
          end
          OP_POP_FRONT: begin
            if (empty) begin
              res_nxt.status = ST_EMPTY;
            end else begin
              rd_addr   = head_r;
              head_nxt  = head_inc;
              count_nxt = count_r - 1'b1;
              state_nxt = S_POP_WAIT;
            end
          end
          OP_POP_BACK: begin
            if (empty) begin
              res_nxt.status = ST_EMPTY;
            end else begin
              rd_addr   = ring_slot;
              count_nxt = count_r - 1'b1;
              state_nxt = S_POP_WAIT;
            end
          end
          OP_SEARCH: begin
            if (empty) begin
              res_nxt.status = ST_NOTFOUND;
            end else begin
              rd_addr       = head_r;
              scan_slot_nxt = head_r;
              idx_nxt       = '0;
              state_nxt     = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_POP_WAIT: begin
        res_nxt.status       = ST_OK;
        res_nxt.popped_value = rd_data;
        state_nxt            = S_RESP;
      end
      S_SCAN: begin
        // The entry at idx_r was read last cycle; the next one is fetched now.
        if (rd_data == val_r) begin
          res_nxt.status         = ST_OK;
          res_nxt.found_position = pos_wide[4:0];
          state_nxt              = S_RESP;
        end else if (idx_inc == count_r) begin
          res_nxt.status = ST_NOTFOUND;
          state_nxt      = S_RESP;
        end else begin
          idx_nxt       = idx_inc;
          scan_slot_nxt = slot_inc;
          rd_addr       = slot_inc;
        end
      end
      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res = res_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= AW'(DEPTH - 1))
    else $error("head pointer out of range");

  a_scan_inside: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> idx_r < count_r)
    else $error("scan index beyond live entries");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_r.status == ST_EMPTY |-> res_r.popped_value == '0 && empty)
    else $error("empty status with data or live entries");

  a_pop_moves_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP_WAIT |-> $past(count_r) == count_r + 1'b1)
    else $error("pop did not remove exactly one entry");

endmodule

@@ hdl/deque_with_search_top.sv @@
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_op, in_value
// out       output     out_valid / out_ready  out_status, out_popped_value, out_found_position
//
// One item is handled at a time; in_ready is high only while the sequencer is idle.
// A push goes from acceptance through S_EXEC and S_RESP to the output register; a pop also
// passes S_POP_WAIT, skipped when empty. A search compares one entry at a time in S_SCAN,
// set by the single compare against the one registered read port of the entry memory.
// Reset empties the queue at once; there is no clearing pass.
// A held result stalls the sequencer only when a second result is ready to be written.
module deque_with_search_top
  import deq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_op,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_popped_value,
  output logic [4:0]         out_found_position
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic          res_valid, res_ready;
  res_t          res;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0]   wr_data, rd_data;
  logic          out_valid_r, out_valid_nxt;
  res_t          out_res_r, out_res_nxt;

  deq_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  deq_seq #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_value  (in_value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_popped_value   = out_res_r.popped_value;
  assign out_found_position = out_res_r.found_position;

endmodule
